/* rtl/sra_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sra_pkg
// Shared sizes, codes and state encoding of the segregated range allocator.
// ----------------------------------------------------------------------------
package sra_pkg;

  // Storage sizes
  localparam int unsigned HEAP_SIZE = 1024;
  localparam int unsigned NUM_SIZES = 64;
  localparam int unsigned FRAMES    = 4;

  localparam int unsigned ADDR_W = $clog2(HEAP_SIZE);
  localparam int unsigned CLS_W  = (NUM_SIZES > 1) ? $clog2(NUM_SIZES) : 1;
  localparam int unsigned FR_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned STEP_W = $clog2(HEAP_SIZE + 1);

  // Field widths
  localparam int unsigned OP_W       = 3;
  localparam int unsigned COUNT_W    = 6;
  localparam int unsigned OFFSET_W   = 10;
  localparam int unsigned FRAME_W    = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned BYTE_W     = 18;
  localparam int unsigned CAP_W      = 11;
  localparam int unsigned INC_W      = 9;
  localparam int unsigned FCNT_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned PROD_W     = ADDR_W + INC_W;

  // Register reset values and saturation limits
  localparam logic [CAP_W-1:0]  CAP_RESET    = CAP_W'(1024);
  localparam logic [INC_W-1:0]  INC_RESET    = INC_W'(32);
  localparam logic [FCNT_W-1:0] FCNT_RESET   = FCNT_W'(3);
  localparam int unsigned       INC_MAX      = 256;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAP    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INC    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = CFG_IDX_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 3'd0,
    OP_RELEASE = 3'd1,
    OP_DEFER   = 3'd2,
    OP_FRAME   = 3'd3,
    OP_CLEAR   = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_CLASS = 2'd2,
    ST_BAD_FRAME = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_LINK,
    S_DEFER,
    S_WALK_CLS,
    S_WALK_PUSH,
    S_RESULT
  } alloc_state_e;

endpackage

/* rtl/segregated_range_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segregated_range_allocator
// Descriptor range allocator: per-class LIFO free lists, bump pointer and
// per-frame deferred release queues, kept in synchronous memories.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | sink      | in_valid_i / in_stall_o | op, count, offset, frame
//  out     | source    | out_valid_o/out_stall_i | status, range_offset,
//          |           |                        | byte_offset, available
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  Accept to result register load: error answers, op reset, unknown ops and
//  deferred release or frame start on an empty queue go straight to S_RESULT;
//  release and bump allocate pass S_HEAD, deferred append S_DEFER, a free list
//  pop S_HEAD and S_LINK; frame start loops S_WALK_CLS and S_WALK_PUSH per
//  queued node (two dependent memory reads: link/size, then head). One item in
//  work at a time; the next transfer is taken the cycle after the load, even
//  while that result is stalled. Async reset clears control state, list valid
//  bits and registers; link and size memories keep their contents.
module segregated_range_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // item channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sra_pkg::OP_W-1:0]     in_op_i,
  input  logic [sra_pkg::COUNT_W-1:0]  in_count_i,
  input  logic [sra_pkg::OFFSET_W-1:0] in_offset_i,
  input  logic [sra_pkg::FRAME_W-1:0]  in_frame_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sra_pkg::STATUS_W-1:0] out_status_o,
  output logic [sra_pkg::OFFSET_W-1:0] out_range_offset_o,
  output logic [sra_pkg::BYTE_W-1:0]   out_byte_offset_o,
  output logic [sra_pkg::CAP_W-1:0]    out_available_o,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sra_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sra_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sra_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers, saturated on use
  // --------------------------------------------------------------------------
  logic [CAP_W-1:0]  cap_q;
  logic [INC_W-1:0]  inc_q;
  logic [FCNT_W-1:0] fcnt_q;
  logic [CAP_W-1:0]  cap_eff;
  logic [INC_W-1:0]  inc_eff;
  logic [FCNT_W-1:0] frames_eff;

  // Writes must arrive only while idle (unenforced); the port never pushes back.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CAP_RESET;
      inc_q  <= INC_RESET;
      fcnt_q <= FCNT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CAP:    cap_q  <= cfg_data_i[CAP_W-1:0];
        CFG_INC:    inc_q  <= cfg_data_i[INC_W-1:0];
        CFG_FRAMES: fcnt_q <= cfg_data_i[FCNT_W-1:0];
        default:    ;
      endcase
    end
  end

  assign cap_eff    = (32'(cap_q) > HEAP_SIZE) ? CAP_W'(HEAP_SIZE) : cap_q;
  assign inc_eff    = (32'(inc_q) > INC_MAX) ? INC_W'(INC_MAX) : inc_q;
  assign frames_eff = (32'(fcnt_q) > FRAMES) ? FCNT_W'(FRAMES) : fcnt_q;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  alloc_state_e state_q, state_d;

  // captured item
  op_e                 op_q;
  logic [COUNT_W-1:0]  cnt_q;
  logic [ADDR_W-1:0]   off_q;

  // work registers
  status_e             status_q, status_d;
  logic [ADDR_W-1:0]   got_q, got_d;
  logic [STEP_W-1:0]   bump_q, bump_d;
  logic [ADDR_W-1:0]   node_q, node_d;     // walk node, or old tail on deferred append
  logic [ADDR_W-1:0]   nxt_q, nxt_d;
  logic [COUNT_W-1:0]  cls_q, cls_d;
  logic [STEP_W-1:0]   steps_q, steps_d;

  // per-frame deferred queues; a queue is empty when its valid bit is low
  logic [ADDR_W-1:0]   dhead_q [FRAMES];
  logic [ADDR_W-1:0]   dhead_d [FRAMES];
  logic [ADDR_W-1:0]   dtail_q [FRAMES];
  logic [ADDR_W-1:0]   dtail_d [FRAMES];
  logic [FRAMES-1:0]   dvld_q, dvld_d;

  // free list heads: memory plus one valid bit per class (empty marker)
  logic [NUM_SIZES-1:0] fh_vld_q, fh_vld_d;

  // output register
  logic                out_valid_q;
  status_e             out_status_q;
  logic [OFFSET_W-1:0] out_range_q;
  logic [BYTE_W-1:0]   out_byte_q;
  logic [CAP_W-1:0]    out_avail_q;
  logic                out_load;

  // --------------------------------------------------------------------------
  // Memories: next link, range size (shared read address), list heads
  // --------------------------------------------------------------------------
  logic [ADDR_W-1:0]  link_mem [HEAP_SIZE];
  logic [COUNT_W-1:0] size_mem [HEAP_SIZE];
  logic [ADDR_W-1:0]  fh_mem   [NUM_SIZES];

  logic               link_we;
  logic [ADDR_W-1:0]  link_wa, link_wd, link_ra, link_rd_q;
  logic               size_we;
  logic [ADDR_W-1:0]  size_wa;
  logic [COUNT_W-1:0] size_wd, size_rd_q;
  logic               fh_we;
  logic [CLS_W-1:0]   fh_wa, fh_ra;
  logic [ADDR_W-1:0]  fh_wd, fh_rd_q;
  logic               fh_hit_q;

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_rd_q <= link_mem[link_ra];
  end

  always_ff @(posedge clk_i) begin
    if (size_we) begin
      size_mem[size_wa] <= size_wd;
    end
    size_rd_q <= size_mem[link_ra];
  end

  always_ff @(posedge clk_i) begin
    if (fh_we) begin
      fh_mem[fh_wa] <= fh_wd;
    end
    fh_rd_q <= fh_mem[fh_ra];
  end

  // --------------------------------------------------------------------------
  // Decode of the incoming item
  // --------------------------------------------------------------------------
  logic              in_acc;
  logic              in_cls_ok;
  logic              in_fr_ok;
  logic [CLS_W-1:0]  in_cls;
  logic [FR_W-1:0]   in_fr;
  logic [ADDR_W-1:0] in_off;
  logic [CLS_W-1:0]  cnt_cls;
  logic              walk_cls_ok;
  logic [CAP_W-1:0]  space_left;
  logic [PROD_W-1:0] byte_prod;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // count is both length and class; except on allocate the offset must lie in storage too
  assign in_cls_ok = (in_count_i != '0) && (32'(in_count_i) < NUM_SIZES)
                     && (32'(in_offset_i) < HEAP_SIZE || op_e'(in_op_i) == OP_ALLOC);
  assign in_fr_ok  = (32'(in_frame_i) < 32'(frames_eff));
  assign in_cls    = CLS_W'(in_count_i);
  assign in_fr     = FR_W'(in_frame_i);
  assign in_off    = ADDR_W'(in_offset_i);
  assign cnt_cls   = CLS_W'(cnt_q);

  // size memory entries of a walked node may hold a class of zero
  assign walk_cls_ok = (cls_q != '0) && (32'(cls_q) < NUM_SIZES);

  assign space_left = (32'(cap_eff) > 32'(bump_q))
                      ? CAP_W'(32'(cap_eff) - 32'(bump_q)) : '0;

  assign byte_prod = PROD_W'(got_q) * PROD_W'(inc_eff);

  // --------------------------------------------------------------------------
  // Sequencer: next state, memory ports and work registers
  // --------------------------------------------------------------------------
  // Every read-modify-write is spread over separate states, so a memory is
  // never read at an entry that is written in the same cycle by a step whose
  // result is still needed; no forwarding path is required.
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    got_d    = got_q;
    bump_d   = bump_q;
    node_d   = node_q;
    nxt_d    = nxt_q;
    cls_d    = cls_q;
    steps_d  = steps_q;
    dhead_d  = dhead_q;
    dtail_d  = dtail_q;
    dvld_d   = dvld_q;
    fh_vld_d = fh_vld_q;
    out_load = 1'b0;

    link_we = 1'b0;
    link_wa = node_q;
    link_wd = node_q;
    link_ra = node_q;
    size_we = 1'b0;
    size_wa = in_off;
    size_wd = in_count_i;
    fh_we   = 1'b0;
    fh_wa   = cnt_cls;
    fh_wd   = off_q;
    fh_ra   = cnt_cls;

    case (state_q)
      S_IDLE: begin
        link_ra = dhead_q[in_fr];
        fh_ra   = in_cls;
        if (in_acc) begin
          status_d = ST_OK;
          got_d    = '0;
          state_d  = S_RESULT;
          case (op_e'(in_op_i))
            OP_ALLOC: begin
              if (!in_cls_ok) begin
                status_d = ST_BAD_CLASS;
              end else begin
                state_d = S_HEAD;
              end
            end
            OP_RELEASE: begin
              if (!in_cls_ok) begin
                status_d = ST_BAD_CLASS;
              end else begin
                size_we = 1'b1;
                state_d = S_HEAD;
              end
            end
            OP_DEFER: begin
              if (!in_cls_ok) begin
                status_d = ST_BAD_CLASS;
              end else if (!in_fr_ok) begin
                status_d = ST_BAD_FRAME;
              end else begin
                // new node ends the queue by pointing to itself
                size_we = 1'b1;
                link_we = 1'b1;
                link_wa = in_off;
                link_wd = in_off;
                if (dvld_q[in_fr]) begin
                  node_d  = dtail_q[in_fr];
                  state_d = S_DEFER;
                end else begin
                  dhead_d[in_fr] = in_off;
                  dvld_d[in_fr]  = 1'b1;
                end
                dtail_d[in_fr] = in_off;
              end
            end
            OP_FRAME: begin
              if (!in_fr_ok) begin
                status_d = ST_BAD_FRAME;
              end else begin
                // queue empties now; the head is held in node_q for the walk
                dvld_d[in_fr]  = 1'b0;
                dtail_d[in_fr] = '0;
                if (dvld_q[in_fr]) begin
                  node_d  = dhead_q[in_fr];
                  steps_d = '0;
                  state_d = S_WALK_CLS;
                end
              end
            end
            OP_CLEAR: begin
              bump_d   = '0;
              fh_vld_d = '0;
              dvld_d   = '0;
              for (int f = 0; f < FRAMES; f++) begin
                dtail_d[f] = '0;
              end
            end
            default: ;
          endcase
        end
      end

      S_HEAD: begin
        link_ra = fh_rd_q;
        if (op_q == OP_ALLOC) begin
          if (fh_hit_q) begin
            got_d   = fh_rd_q;
            state_d = S_LINK;
          end else if (32'(space_left) < 32'(cnt_q)) begin
            status_d = ST_FULL;
            state_d  = S_RESULT;
          end else begin
            got_d   = ADDR_W'(bump_q);
            bump_d  = STEP_W'(32'(bump_q) + 32'(cnt_q));
            state_d = S_RESULT;
          end
        end else begin
          // release: push onto the class list
          link_we = 1'b1;
          link_wa = off_q;
          link_wd = fh_hit_q ? fh_rd_q : off_q;
          fh_we   = 1'b1;
          fh_wd   = off_q;
          fh_vld_d[cnt_cls] = 1'b1;
          state_d = S_RESULT;
        end
      end

      S_LINK: begin
        // pop: a self link marks the last node of the list
        if (link_rd_q == got_q) begin
          fh_vld_d[cnt_cls] = 1'b0;
        end else begin
          fh_we = 1'b1;
          fh_wd = link_rd_q;
        end
        state_d = S_RESULT;
      end

      S_DEFER: begin
        link_we = 1'b1;
        link_wa = node_q;
        link_wd = off_q;
        state_d = S_RESULT;
      end

      S_WALK_CLS: begin
        nxt_d   = link_rd_q;
        cls_d   = size_rd_q;
        fh_ra   = CLS_W'(size_rd_q);
        state_d = S_WALK_PUSH;
      end

      S_WALK_PUSH: begin
        link_ra = nxt_q;
        if (walk_cls_ok) begin
          link_we = 1'b1;
          link_wa = node_q;
          link_wd = fh_hit_q ? fh_rd_q : node_q;
          fh_we   = 1'b1;
          fh_wa   = CLS_W'(cls_q);
          fh_wd   = node_q;
          fh_vld_d[CLS_W'(cls_q)] = 1'b1;
        end
        steps_d = STEP_W'(32'(steps_q) + 32'd1);
        if (nxt_q == node_q || 32'(steps_d) == HEAP_SIZE) begin
          state_d = S_RESULT;
        end else begin
          node_d  = nxt_q;
          state_d = S_WALK_CLS;
        end
      end

      S_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      bump_q   <= '0;
      dvld_q   <= '0;
      fh_vld_q <= '0;
      fh_hit_q <= 1'b0;
      for (int f = 0; f < FRAMES; f++) begin
        dtail_q[f] <= '0;
      end
    end else begin
      state_q  <= state_d;
      bump_q   <= bump_d;
      dvld_q   <= dvld_d;
      fh_vld_q <= fh_vld_d;
      fh_hit_q <= fh_vld_q[fh_ra];
      dtail_q  <= dtail_d;
    end
  end

  // payload and work registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= op_e'(in_op_i);
      cnt_q <= in_count_i;
      off_q <= in_off;
    end
    status_q <= status_d;
    got_q    <= got_d;
    node_q   <= node_d;
    nxt_q    <= nxt_d;
    cls_q    <= cls_d;
    steps_q  <= steps_d;
    dhead_q  <= dhead_d;
  end

  // output register: frees the sequencer while a result waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= status_q;
      out_range_q  <= OFFSET_W'(got_q);
      out_byte_q   <= BYTE_W'(byte_prod);
      out_avail_q  <= space_left;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_status_o       = out_status_q;
  assign out_range_offset_o = out_range_q;
  assign out_byte_offset_o  = out_byte_q;
  assign out_available_o    = out_avail_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // op reset empties every free list and deferred queue
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_op_i == OP_CLEAR) |=> (fh_vld_q == '0 && dvld_q == '0))
    else $error("list valid bits not cleared by reset op");

  // a failed allocate never hands out an offset
  a_full_no_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_status_o == ST_FULL) |-> (out_range_offset_o == '0))
    else $error("offset returned with heap full");

  // byte offset follows range offset
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_range_offset_o == '0) |-> (out_byte_offset_o == '0))
    else $error("nonzero byte offset for zero range offset");

  // frame start walk is bounded by the heap size
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK_PUSH) |-> (32'(steps_q) < HEAP_SIZE))
    else $error("deferred walk exceeded heap size");

endmodule

/* verif/sra_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sra_checker
// Watches the item, result and register channels of the range allocator,
// keeps its own copy of the heap bookkeeping and compares every result.
// ----------------------------------------------------------------------------
module sra_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [sra_pkg::OP_W-1:0]       in_op_i,
  input  logic [sra_pkg::COUNT_W-1:0]    in_count_i,
  input  logic [sra_pkg::OFFSET_W-1:0]   in_offset_i,
  input  logic [sra_pkg::FRAME_W-1:0]    in_frame_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [sra_pkg::STATUS_W-1:0]   out_status_i,
  input  logic [sra_pkg::OFFSET_W-1:0]   out_range_offset_i,
  input  logic [sra_pkg::BYTE_W-1:0]     out_byte_offset_i,
  input  logic [sra_pkg::CAP_W-1:0]      out_available_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [sra_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sra_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  import sra_pkg::*;

  localparam logic [CAP_W-1:0] NO_NODE = CAP_W'(HEAP_SIZE);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] range_offset;
    logic [BYTE_W-1:0]   byte_offset;
    logic [CAP_W-1:0]    available;
  } alloc_result_t;

  alloc_result_t expected_q[$];

  // register copies
  logic [CAP_W-1:0]   cap_reg;
  logic [INC_W-1:0]   inc_reg;
  logic [FCNT_W-1:0]  fcnt_reg;

  // heap bookkeeping
  logic [CAP_W-1:0]   bump;
  logic [ADDR_W-1:0]  link_mem  [HEAP_SIZE];
  logic [COUNT_W-1:0] size_mem  [HEAP_SIZE];
  logic [CAP_W-1:0]   class_head[NUM_SIZES];
  logic [CAP_W-1:0]   queue_head[FRAMES];
  logic [ADDR_W-1:0]  queue_tail[FRAMES];

  function automatic bit class_ok(input logic [COUNT_W-1:0] c);
    return (c != '0) && (int'(c) < NUM_SIZES);
  endfunction

  function automatic logic [CAP_W-1:0] space_left();
    logic [CAP_W-1:0] cap;
    cap = (cap_reg > HEAP_SIZE) ? CAP_W'(HEAP_SIZE) : cap_reg;
    return (cap > bump) ? cap - bump : '0;
  endfunction

  task automatic clear_allocator();
    bump = '0;
    for (int i = 0; i < NUM_SIZES; i++) class_head[i] = NO_NODE;
    for (int i = 0; i < FRAMES; i++) begin
      queue_head[i] = NO_NODE;
      queue_tail[i] = '0;
    end
  endtask

  // LIFO push; the last node of a list links to itself
  task automatic push_class(input logic [COUNT_W-1:0] cls, input logic [ADDR_W-1:0] node);
    link_mem[node] = (class_head[cls] == NO_NODE) ? node : class_head[cls][ADDR_W-1:0];
    class_head[cls] = CAP_W'(node);
  endtask

  task automatic predict_item(input logic [OP_W-1:0] op, input logic [COUNT_W-1:0] cnt,
                              input logic [OFFSET_W-1:0] off, input logic [FRAME_W-1:0] fr,
                              output alloc_result_t res);
    logic [CAP_W-1:0]   head;
    logic [CAP_W-1:0]   node;
    logic [ADDR_W-1:0]  nxt;
    logic [COUNT_W-1:0] cls;
    logic [ADDR_W-1:0]  got;
    int unsigned        steps;
    int unsigned        frames;
    int unsigned        inc;
    bit                 walking;
    status_e            st;
    frames = (fcnt_reg > FRAMES) ? FRAMES : fcnt_reg;
    inc    = (inc_reg > INC_MAX) ? INC_MAX : inc_reg;
    st     = ST_OK;
    got    = '0;
    case (op)
      OP_ALLOC: begin
        if (!class_ok(cnt)) begin
          st = ST_BAD_CLASS;
        end else if (class_head[cnt] != NO_NODE) begin
          head = class_head[cnt];
          nxt  = link_mem[head[ADDR_W-1:0]];
          class_head[cnt] = (CAP_W'(nxt) == head) ? NO_NODE : CAP_W'(nxt);
          got = head[ADDR_W-1:0];
        end else if (space_left() < cnt) begin
          st = ST_FULL;
        end else begin
          got  = bump[ADDR_W-1:0];
          bump = bump + CAP_W'(cnt);
        end
      end
      OP_RELEASE: begin
        if (!class_ok(cnt) || off >= HEAP_SIZE) begin
          st = ST_BAD_CLASS;
        end else begin
          size_mem[off] = cnt;
          push_class(cnt, off);
        end
      end
      OP_DEFER: begin
        if (!class_ok(cnt) || off >= HEAP_SIZE) begin
          st = ST_BAD_CLASS;
        end else if (fr >= frames) begin
          st = ST_BAD_FRAME;
        end else begin
          size_mem[off] = cnt;
          link_mem[off] = off;
          if (queue_head[fr] == NO_NODE) queue_head[fr] = CAP_W'(off);
          else link_mem[queue_tail[fr]] = off;
          queue_tail[fr] = off;
        end
      end
      OP_FRAME: begin
        if (fr >= frames) begin
          st = ST_BAD_FRAME;
        end else begin
          // oldest first; bounded so a looped chain cannot hang the walk
          node    = queue_head[fr];
          steps   = 0;
          walking = 1'b1;
          while (walking && node < HEAP_SIZE && steps < HEAP_SIZE) begin
            nxt = link_mem[node[ADDR_W-1:0]];
            cls = size_mem[node[ADDR_W-1:0]];
            if (class_ok(cls)) push_class(cls, node[ADDR_W-1:0]);
            steps++;
            if (CAP_W'(nxt) == node) walking = 1'b0;
            else node = CAP_W'(nxt);
          end
          queue_head[fr] = NO_NODE;
          queue_tail[fr] = '0;
        end
      end
      OP_CLEAR: clear_allocator();
      default: ;
    endcase
    res.status       = st;
    res.range_offset = got;
    res.byte_offset  = BYTE_W'(got * inc);
    res.available    = space_left();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    alloc_result_t want;
    alloc_result_t fresh;
    if (!rst_ni) begin
      cap_reg  = CAP_RESET;
      inc_reg  = INC_RESET;
      fcnt_reg = FCNT_RESET;
      for (int i = 0; i < HEAP_SIZE; i++) begin
        link_mem[i] = '0;
        size_mem[i] = '0;
      end
      clear_allocator();
      expected_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // results first, so a stray result is never matched to a fresh item
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with no item outstanding");
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (out_status_i !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status_i);
            fail_count_o++;
          end
          if (out_range_offset_i !== want.range_offset) begin
            $error("range_offset: expected %0d, actual %0d",
                   want.range_offset, out_range_offset_i);
            fail_count_o++;
          end
          if (out_byte_offset_i !== want.byte_offset) begin
            $error("byte_offset: expected %0d, actual %0d",
                   want.byte_offset, out_byte_offset_i);
            fail_count_o++;
          end
          if (out_available_i !== want.available) begin
            $error("available: expected %0d, actual %0d", want.available, out_available_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_item(in_op_i, in_count_i, in_offset_i, in_frame_i, fresh);
        expected_q = {expected_q, fresh};
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_CAP:    cap_reg  = cfg_data_i[CAP_W-1:0];
          CFG_INC:    inc_reg  = cfg_data_i[INC_W-1:0];
          CFG_FRAMES: fcnt_reg = cfg_data_i[FCNT_W-1:0];
          default: ;
        endcase
      end
      pending_o = expected_q.size();
    end
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the range allocator with a directed opening and random item streams
// under several register settings; sra_checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
  import sra_pkg::*;

  // index with no register behind it; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       in_op = '0;
  logic [COUNT_W-1:0]    in_count = '0;
  logic [OFFSET_W-1:0]   in_offset = '0;
  logic [FRAME_W-1:0]    in_frame = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [OFFSET_W-1:0]   out_range_offset;
  logic [BYTE_W-1:0]     out_byte_offset;
  logic [CAP_W-1:0]      out_available;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;

  // chance in percent that a side idles in a given cycle
  int idle_pct = 13;

  // bookkeeping used only to shape the stimulus and the run summary
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [COUNT_W-1:0] count;
  } sent_item_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [COUNT_W-1:0]  count;
  } live_range_t;

  sent_item_t  sent_q[$];
  live_range_t live[$];   // ranges handed out and not yet given back
  int n_items, n_results, n_settings;
  int n_ok, n_full, n_bad_class, n_bad_frame;

  always #5 clk_i = ~clk_i;

  segregated_range_allocator dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .in_op_i            (in_op),
    .in_count_i         (in_count),
    .in_offset_i        (in_offset),
    .in_frame_i         (in_frame),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .out_status_o       (out_status),
    .out_range_offset_o (out_range_offset),
    .out_byte_offset_o  (out_byte_offset),
    .out_available_o    (out_available),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  sra_checker chk (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .in_op_i            (in_op),
    .in_count_i         (in_count),
    .in_offset_i        (in_offset),
    .in_frame_i         (in_frame),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .out_status_i       (out_status),
    .out_range_offset_i (out_range_offset),
    .out_byte_offset_i  (out_byte_offset),
    .out_available_i    (out_available),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  // Result-side back-pressure, redrawn every cycle at the falling edge.
  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  // Track transfers: successful allocations feed the pool of live ranges,
  // which later release and deferred-release items draw from.
  always @(posedge clk_i) begin : track
    sent_item_t s;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        n_results++;
        case (out_status)
          ST_OK:        n_ok++;
          ST_FULL:      n_full++;
          ST_BAD_CLASS: n_bad_class++;
          default:      n_bad_frame++;
        endcase
        if (sent_q.size() > 0) begin
          s = sent_q.pop_front();
          if (s.op == OP_ALLOC && out_status == ST_OK)
            live = {live, live_range_t'{offset: out_range_offset, count: s.count}};
          else if (s.op == OP_CLEAR)
            live.delete();
        end
      end
      if (in_valid && !in_stall) begin
        n_items++;
        sent_q = {sent_q, sent_item_t'{op: in_op, count: in_count}};
      end
    end
  end

  // One item transfer. Entered and left at a falling edge; valid stays high
  // between back-to-back items so it is never dropped and raised in one step.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [COUNT_W-1:0] cnt,
                           input logic [OFFSET_W-1:0] off, input logic [FRAME_W-1:0] fr);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid  <= 1'b1;
    in_op     <= op;
    in_count  <= cnt;
    in_offset <= off;
    in_frame  <= fr;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  // Register write; cfg_valid is left high so the caller drops it once.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
  endtask

  // Stop feeding items and wait for every outstanding result.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  // Registers are only rewritten with the allocator idle.
  task automatic new_setting(input int cap, input int inc, input int frames, input bit spare);
    drain();
    write_reg(CFG_CAP, CFG_DATA_W'(cap));
    write_reg(CFG_INC, CFG_DATA_W'(inc));
    write_reg(CFG_FRAMES, CFG_DATA_W'(frames));
    if (spare) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Mostly well-formed traffic: allocate small classes, hand the ranges back
  // now or through a frame queue, and retire frames. The rest is noise.
  task automatic random_item();
    int          pick;
    int          idx;
    live_range_t lr;
    pick = $urandom_range(99);
    if (pick < 36) begin
      send_item(OP_ALLOC,
                ($urandom_range(99) < 80) ? COUNT_W'($urandom_range(6, 1))
                                          : COUNT_W'($urandom_range(63)),
                OFFSET_W'($urandom), FRAME_W'($urandom));
    end else if (pick < 70 && live.size() > 0) begin
      idx = $urandom_range(live.size() - 1);
      lr  = live[idx];
      live.delete(idx);
      if (pick < 55) send_item(OP_RELEASE, lr.count, lr.offset, FRAME_W'($urandom));
      else send_item(OP_DEFER, lr.count, lr.offset, FRAME_W'($urandom));
    end else if (pick < 84) begin
      send_item(OP_FRAME, COUNT_W'($urandom), OFFSET_W'($urandom), FRAME_W'($urandom));
    end else if (pick < 86) begin
      send_item(OP_CLEAR, COUNT_W'($urandom), OFFSET_W'($urandom), FRAME_W'($urandom));
    end else if (pick < 90) begin
      // op codes past the defined set
      send_item(OP_W'($urandom_range(7, int'(OP_CLEAR) + 1)), COUNT_W'($urandom),
                OFFSET_W'($urandom), FRAME_W'($urandom));
    end else begin
      send_item(OP_W'($urandom_range(int'(OP_CLEAR))), COUNT_W'($urandom),
                OFFSET_W'($urandom), FRAME_W'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed opening under the reset register values (1024, 32, 3 frames).
    send_item(OP_ALLOC, 0, 0, 0);           // class zero
    send_item(OP_ALLOC, 63, 0, 0);          // largest class, bump from 0
    send_item(OP_ALLOC, 1, 0, 0);
    send_item(OP_RELEASE, 0, 5, 0);         // class zero on release
    send_item(OP_RELEASE, 5, 1023, 0);      // top offset onto class 5
    send_item(OP_ALLOC, 5, 0, 0);           // pops 1023, widest byte offset
    send_item(OP_ALLOC, 5, 0, 0);           // list empty again, bumps
    send_item(OP_DEFER, 0, 63, 3);          // class checked before frame
    send_item(OP_DEFER, 1, 63, 3);          // frame past frame_count
    send_item(OP_DEFER, 2, 100, 0);
    send_item(OP_DEFER, 2, 200, 0);
    send_item(OP_DEFER, 7, 300, 0);
    send_item(OP_FRAME, 0, 0, 3);           // bad frame on frame start
    send_item(OP_FRAME, 0, 0, 0);           // queue moves in order
    send_item(OP_ALLOC, 2, 0, 0);           // LIFO: 200 first
    send_item(OP_ALLOC, 2, 0, 0);
    send_item(OP_ALLOC, 7, 0, 0);
    send_item(OP_FRAME, 0, 0, 1);           // empty queue
    send_item(OP_RELEASE, 3, 42, 0);        // same range released twice
    send_item(OP_RELEASE, 3, 42, 0);
    send_item(OP_ALLOC, 3, 0, 0);
    send_item(OP_ALLOC, 3, 0, 0);
    for (int o = int'(OP_CLEAR) + 1; o < 8; o++) send_item(OP_W'(o), 63, 1023, 3);
    send_item(OP_CLEAR, 0, 0, 0);
    send_item(OP_ALLOC, 63, 0, 0);          // bump restarts at 0

    // Full heap, widest step, every frame usable.
    new_setting(1024, 256, 4, 1'b0);
    repeat (115) random_item();

    // Tiny heap and step, single frame: frequent heap-full answers.
    new_setting(64, 1, 1, 1'b1);
    repeat (115) random_item();

    // Oversized registers saturate; no idling on either side here.
    new_setting(2047, 511, 7, 1'b0);
    idle_pct = 0;
    repeat (115) random_item();
    idle_pct = 13;

    // One-descriptor heap, zero step, no frames at all.
    new_setting(1, 0, 0, 1'b0);
    send_item(OP_ALLOC, 1, 0, 0);
    send_item(OP_ALLOC, 1, 0, 0);           // heap full
    send_item(OP_ALLOC, 63, 0, 0);          // heap full
    send_item(OP_DEFER, 1, 0, 0);           // no frame is valid
    repeat (50) random_item();

    // Random register values over the whole field range.
    new_setting($urandom_range(2047), $urandom_range(511), $urandom_range(7), 1'b1);
    repeat (130) random_item();

    drain();
    $display("Run covered %0d items and %0d results over %0d register settings",
             n_items, n_results, n_settings + 1);
    $display("Result status mix: %0d ok, %0d heap full, %0d bad class, %0d bad frame",
             n_ok, n_full, n_bad_class, n_bad_frame);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Watchdog: far beyond any correct run, including long frame walks.
  initial begin
    #(40_000_000);
    $display("Timeout with %0d results outstanding", pending);
    $display("Mismatches found");
    $finish;
  end

endmodule

/* sim.f */
rtl/sra_pkg.sv
rtl/segregated_range_allocator.sv
verif/sra_checker.sv
verif/tb.sv
